// ----- rtl/core/cps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cps_pkg: shared types and codes for the column projection segmenter
// Result kinds, run phases, register map and the record / bundle structs
// that carry results from the segmentation core to the result queue.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int CPS_MAX_WIDTH  = 1024;
  localparam int CPS_MAX_HEIGHT = 1024;

  localparam int CNT_W   = 11;  // column / row counters, widths, thresholds
  localparam int POS_W   = 10;  // column position
  localparam int SUM_W   = 24;  // space width total
  localparam int NUM_W   = 16;  // space count
  localparam int PIX_W   = 8;
  localparam int NSLOT   = 3;   // most results one pixel can cause

  // Result kinds
  localparam logic [1:0] KIND_NEWLINE = 2'd0;
  localparam logic [1:0] KIND_SEGMENT = 2'd1;
  localparam logic [1:0] KIND_SPACE   = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  // Run phases
  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_BLACK = 2'd1;
  localparam logic [1:0] PH_GAP   = 2'd2;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [1:0] REG_COL_THRESH  = 2'd1;
  localparam logic [1:0] REG_BLACK_LEVEL = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] image_width;
    logic [CNT_W-1:0] column_threshold;
    logic [PIX_W-1:0] black_level;
  } cps_cfg_t;

  typedef struct packed {
    logic             last;
    logic [NUM_W-1:0] space_tally;
    logic [SUM_W-1:0] space_sum;
    logic [CNT_W-1:0] band_height;
    logic [CNT_W-1:0] seg_width;
    logic [POS_W-1:0] position;
    logic [1:0]       kind;
  } cps_rec_t;

  // All results of one pixel, in emission order from slot 0
  typedef struct packed {
    logic [1:0]           cnt;
    cps_rec_t [NSLOT-1:0] rec;
  } cps_bundle_t;

  function automatic cps_rec_t mk_rec(input logic [1:0]       kind,
                                      input logic [POS_W-1:0] pos,
                                      input logic [CNT_W-1:0] w,
                                      input logic [CNT_W-1:0] h,
                                      input logic [SUM_W-1:0] sum,
                                      input logic [NUM_W-1:0] num);
    cps_rec_t r;
    r.last        = 1'b0;
    r.space_tally = num;
    r.space_sum   = sum;
    r.band_height = h;
    r.seg_width   = w;
    r.position    = pos;
    r.kind        = kind;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/cps_seg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cps_seg: segmentation core
// Input register, per-pixel column counting and run tracking; builds the
// bundle of results for each pixel and pushes non-empty ones into the result queue.
// ----------------------------------------------------------------------------
module cps_seg
  import cps_pkg::*;
#(
  parameter int MAX_WIDTH  = CPS_MAX_WIDTH,
  parameter int MAX_HEIGHT = CPS_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cps_cfg_t    cfg,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel
  input  logic [1:0]  in_tuser,   // [0] last_in_column, [1] new_image
  input  logic        in_tlast,   // last_in_band
  input  logic        q_full,
  output logic        push,
  output cps_bundle_t bundle
);

  localparam logic [CNT_W-1:0] HCAP = CNT_W'((MAX_HEIGHT < 2047) ? MAX_HEIGHT : 2047);
  localparam logic [CNT_W-1:0] WCAP = CNT_W'((MAX_WIDTH  < 2047) ? MAX_WIDTH  : 2047);

  // input register
  logic             s1_v_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic             s1_lic_r, s1_lib_r, s1_new_r;

  // state
  logic [CNT_W-1:0] dot_r, dot_nxt;
  logic [CNT_W-1:0] rows_r, rows_nxt;
  logic [CNT_W-1:0] height_r, height_nxt;
  logic             first_r, first_nxt;
  logic [CNT_W-1:0] colidx_r, colidx_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [SUM_W-1:0] tot_r, tot_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;

  logic             go;
  logic             col_end;
  logic [CNT_W-1:0] dot1, rows1, thr, len1, col11;
  logic [POS_W-1:0] col;
  logic             black;
  logic [SUM_W-1:0] tot0;
  logic [NUM_W-1:0] num0;
  logic [SUM_W:0]   sum_ext;
  logic [3:0]       cflag;
  cps_rec_t [3:0]   cand;
  cps_rec_t [NSLOT-1:0] slots;
  logic [1:0]       n;
  logic [1:0]       mid_phase;
  logic [POS_W-1:0] mid_start;
  logic [CNT_W-1:0] mid_len;

  assign go        = s1_v_r && ((bundle.cnt == 2'd0) || !q_full);
  assign push      = go && (bundle.cnt != 2'd0);
  assign in_tready = !s1_v_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_pix_r <= in_tdata;
      s1_lic_r <= in_tuser[0];
      s1_new_r <= in_tuser[1];
      s1_lib_r <= in_tlast;
    end
  end

  always_comb begin
    col_end = s1_lic_r || s1_lib_r;
    tot0    = s1_new_r ? '0 : tot_r;
    num0    = s1_new_r ? '0 : num_r;
    dot1    = ((s1_pix_r < cfg.black_level) && (dot_r < HCAP)) ? dot_r + 1'b1 : dot_r;
    rows1   = (rows_r < HCAP) ? rows_r + 1'b1 : rows_r;
    thr     = (cfg.column_threshold == '0) ? CNT_W'(1) : cfg.column_threshold;
    black   = dot1 >= thr;
    col11   = cfg.image_width - CNT_W'(1) - colidx_r;
    col     = col11[POS_W-1:0];
    len1    = (len_r < WCAP) ? len_r + 1'b1 : len_r;
    sum_ext = {1'b0, tot0} + (SUM_W+1)'(len_r);

    dot_nxt    = dot1;
    rows_nxt   = rows1;
    height_nxt = height_r;
    first_nxt  = first_r;
    colidx_nxt = colidx_r;
    phase_nxt  = phase_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    tot_nxt    = tot0;
    num_nxt    = num0;
    mid_phase  = phase_r;
    mid_start  = start_r;
    mid_len    = len_r;
    cflag      = '0;
    cand[0]    = mk_rec(KIND_NEWLINE, '0, '0, rows1, '0, '0);
    cand[1]    = mk_rec(KIND_SEGMENT, start_r, len_r, '0, '0, '0);
    cand[2]    = mk_rec(KIND_SEGMENT, '0, '0, '0, '0, '0);
    cand[3]    = mk_rec(KIND_END, '0, '0, '0, '0, '0);

    if (col_end) begin
      if (first_r) begin
        height_nxt = rows1;
        first_nxt  = 1'b0;
        cflag[0]   = 1'b1;
      end

      unique case (phase_r)
        PH_BLACK: begin
          if (black) begin
            mid_start = col;
            mid_len   = len1;
          end else begin
            cflag[1]  = 1'b1;
            mid_phase = PH_GAP;
            mid_start = col;
            mid_len   = CNT_W'(1);
          end
        end
        PH_GAP: begin
          if (black) begin
            cflag[1]      = 1'b1;
            cand[1].kind  = KIND_SPACE;
            tot_nxt       = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            num_nxt       = (num0 != '1) ? num0 + 1'b1 : num0;
            mid_phase     = PH_BLACK;
            mid_start     = col;
            mid_len       = CNT_W'(1);
          end else begin
            mid_start = col;
            mid_len   = len1;
          end
        end
        default: begin  // leading white
          if (black) begin
            mid_phase = PH_BLACK;
            mid_start = col;
            mid_len   = CNT_W'(1);
          end
        end
      endcase

      dot_nxt    = '0;
      rows_nxt   = '0;
      colidx_nxt = colidx_r + 1'b1;
      phase_nxt  = mid_phase;
      start_nxt  = mid_start;
      len_nxt    = mid_len;

      if (s1_lib_r) begin
        cflag[2]          = (mid_phase == PH_BLACK);
        cand[2].position  = mid_start;
        cand[2].seg_width = mid_len;
        cflag[3]          = 1'b1;
        cand[3].space_sum   = tot_nxt;
        cand[3].space_tally = num_nxt;
        phase_nxt  = PH_LEAD;
        start_nxt  = '0;
        len_nxt    = '0;
        first_nxt  = 1'b1;
        colidx_nxt = '0;
        height_nxt = '0;
      end
    end

    // pack the emitted records into consecutive slots
    slots = '0;
    n     = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (cflag[i] && (n != 2'd3)) begin
        slots[n] = cand[i];
        n        = n + 2'd1;
      end
    end
    if (n != 2'd0) begin
      slots[2'(n - 2'd1)].last = 1'b1;
    end
    bundle.rec = slots;
    bundle.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r    <= '0;
      rows_r   <= '0;
      height_r <= '0;
      first_r  <= 1'b1;
      colidx_r <= '0;
      phase_r  <= PH_LEAD;
      start_r  <= '0;
      len_r    <= '0;
      tot_r    <= '0;
      num_r    <= '0;
    end else if (go) begin
      dot_r    <= dot_nxt;
      rows_r   <= rows_nxt;
      height_r <= height_nxt;
      first_r  <= first_nxt;
      colidx_r <= colidx_nxt;
      phase_r  <= phase_nxt;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      tot_r    <= tot_nxt;
      num_r    <= num_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/cps_outq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cps_outq: result queue
// Two-entry queue of per-pixel result bundles; the head bundle is sent out
// one record per transfer, tlast on its final record.
// ----------------------------------------------------------------------------
module cps_outq
  import cps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  cps_bundle_t bundle,
  output logic        q_full,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // position, seg_width, band_height, space_sum, space_tally
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast   // last
);

  cps_bundle_t q_mem [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic [1:0]  sub_r;
  cps_bundle_t head;
  cps_rec_t    rec;
  logic        xfer, pop;

  assign head       = q_mem[rd_ptr_r];
  assign rec        = head.rec[sub_r];
  assign out_tvalid = (count_r != 2'd0);
  assign out_tuser  = rec.kind;
  assign out_tdata  = {rec.space_tally, rec.space_sum, rec.band_height,
                       rec.seg_width, rec.position};
  assign out_tlast  = rec.last;
  assign q_full     = (count_r == 2'd2);
  assign xfer       = out_tvalid && out_tready;
  assign pop        = xfer && rec.last;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      sub_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
      if (xfer) begin
        sub_r <= rec.last ? 2'd0 : sub_r + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/column_projection_segmenter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// column_projection_segmenter_top: vertical projection segmenter
// Splits a text band into character segments and spaces from per-column
// black pixel counts.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*: one pixel per transfer, columns right to left, rows top to bottom.
//    tdata = grey value, tuser[0] = last_in_column, tuser[1] = new_image,
//    tlast = last_in_band (also closes the current column).
//  - out_*: one result record per transfer; tuser = kind (new line, segment,
//    space, band end), tlast marks the final record caused by one pixel.
//  - cfg_*: APB-style registers: 0x0 image_width, 0x4 column_threshold,
//    0x8 black_level. Write only while the stream is idle.
//  - Throughput: one pixel per cycle unless a pixel with results meets a full
//    queue. A pixel that ends a column emits up to three records, one per
//    output cycle; a two-bundle result queue lets input flow while they drain.
//  - Record path: the input register takes the pixel at the transfer, then its
//    records are pushed into the result queue, whose head record is valid.
//  - Receiver stall: the queue fills, then in_tready drops once a pixel with
//    results cannot be stored; pixels with no results still pass.
//  - Reset (rst_n low, synchronous): registers return to defaults, counters
//    and run state clear, queue empties. No clearing pass is needed.
// ----------------------------------------------------------------------------
module column_projection_segmenter_top
  import cps_pkg::*;
#(
  parameter int MAX_WIDTH  = CPS_MAX_WIDTH,
  parameter int MAX_HEIGHT = CPS_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  // pixel stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] pixel
  input  logic [1:0]  in_tuser,     // [0] last_in_column, [1] new_image
  input  logic        in_tlast,     // last_in_band
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,    // [9:0] position, [20:10] seg_width,
                                    // [31:21] band_height, [55:32] space_sum,
                                    // [71:56] space_tally
  output logic [1:0]  out_tuser,    // [1:0] kind
  output logic        out_tlast,    // last
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cps_cfg_t    cfg_r;
  logic        wr_en;
  logic        q_full;
  logic        push;
  cps_bundle_t bundle;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register file; word index from paddr[3:2]
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width      <= CNT_W'(1024);
      cfg_r.column_threshold <= CNT_W'(1);
      cfg_r.black_level      <= PIX_W'(128);
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        REG_IMAGE_WIDTH: cfg_r.image_width      <= cfg_pwdata[CNT_W-1:0];
        REG_COL_THRESH:  cfg_r.column_threshold <= cfg_pwdata[CNT_W-1:0];
        REG_BLACK_LEVEL: cfg_r.black_level      <= cfg_pwdata[PIX_W-1:0];
        default: ;  // unmapped word, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_IMAGE_WIDTH: cfg_prdata = 32'(cfg_r.image_width);
      REG_COL_THRESH:  cfg_prdata = 32'(cfg_r.column_threshold);
      REG_BLACK_LEVEL: cfg_prdata = 32'(cfg_r.black_level);
      default:         cfg_prdata = '0;
    endcase
  end

  // counting and run tracking
  cps_seg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .bundle    (bundle)
  );

  // result queue and record serializer
  cps_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .bundle     (bundle),
    .q_full     (q_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/core/cps_chk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cps_chk: port-level checks for the segmenter
// Watches the stream ports; bound to the top level.
// ----------------------------------------------------------------------------
module cps_chk
  import cps_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // a pending record is held until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped without a transfer");

  // band end is always the final record of its pixel
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_END) |-> out_tlast)
    else $error("band end record without tlast");

  // new line and band end carry no width
  a_no_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == KIND_NEWLINE) || (out_tuser == KIND_END))
      |-> (out_tdata[20:10] == 11'd0))
    else $error("nonzero seg_width on new line or band end");

  // reset empties the queue and opens the input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("stream not idle after reset");

endmodule

bind column_projection_segmenter_top cps_chk u_cps_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// ----- sim/cps_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cps_tb_pkg: result tracker for the column projection segmenter bench
// Mirrors the column counters, run state and space totals of the segmenter,
// builds the records each accepted pixel should cause and checks the result
// stream against them in order.
// ----------------------------------------------------------------------------
package cps_tb_pkg;
  import cps_pkg::*;

  localparam int HEIGHT_CAP = (CPS_MAX_HEIGHT < 2047) ? CPS_MAX_HEIGHT : 2047;
  localparam int WIDTH_CAP  = (CPS_MAX_WIDTH < 2047) ? CPS_MAX_WIDTH : 2047;

  class segment_tracker;
    // register copies
    logic [CNT_W-1:0] image_width;
    logic [CNT_W-1:0] col_threshold;
    logic [PIX_W-1:0] black_level;

    // column and run state
    logic [CNT_W-1:0] dots;
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] height;
    logic [CNT_W-1:0] col_index;
    logic [CNT_W-1:0] run_len;
    logic [POS_W-1:0] run_start;
    logic [1:0]       phase;
    logic             first_col;
    logic [SUM_W-1:0] space_sum;
    logic [NUM_W-1:0] space_num;

    cps_rec_t expected[$];
    cps_rec_t batch[$];
    int       errors;

    function new();
      image_width   = 11'd1024;
      col_threshold = 11'd1;
      black_level   = 8'd128;
      dots          = '0;
      rows          = '0;
      height        = '0;
      col_index     = '0;
      run_len       = '0;
      run_start     = '0;
      phase         = PH_LEAD;
      first_col     = 1'b1;
      space_sum     = '0;
      space_num     = '0;
      errors        = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_IMAGE_WIDTH: image_width   = value[CNT_W-1:0];
        REG_COL_THRESH:  col_threshold = value[CNT_W-1:0];
        REG_BLACK_LEVEL: black_level   = value[PIX_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void queue_record(logic [1:0] kind, logic [POS_W-1:0] pos,
                               logic [CNT_W-1:0] w, logic [CNT_W-1:0] h,
                               logic [SUM_W-1:0] sum, logic [NUM_W-1:0] num);
      cps_rec_t r;
      r.kind        = kind;
      r.position    = pos;
      r.seg_width   = w;
      r.band_height = h;
      r.space_sum   = sum;
      r.space_tally = num;
      r.last        = 1'b0;
      batch.push_back(r);
    endfunction

    function void begin_run(logic [1:0] ph, logic [POS_W-1:0] col);
      phase     = ph;
      run_start = col;
      run_len   = 11'd1;
    endfunction

    // runs grow leftward, so the start follows the newest column
    function void extend_run(logic [POS_W-1:0] col);
      run_start = col;
      if (run_len < WIDTH_CAP) run_len = run_len + 1'b1;
    endfunction

    function void note_pixel(logic [7:0] pix, logic col_last, logic band_last,
                             logic new_img);
      logic [CNT_W-1:0] thr;
      logic [POS_W-1:0] col;
      logic [SUM_W:0]   wide_sum;
      logic             blk;
      if (new_img) begin
        space_sum = '0;
        space_num = '0;
      end
      if (pix < black_level && dots < HEIGHT_CAP) dots = dots + 1'b1;
      if (rows < HEIGHT_CAP) rows = rows + 1'b1;
      if (!(col_last || band_last)) return;

      batch.delete();
      thr = (col_threshold == '0) ? 11'd1 : col_threshold;
      blk = (dots >= thr);
      col = POS_W'(image_width - 11'd1 - col_index);

      if (first_col) begin
        height    = rows;
        first_col = 1'b0;
        queue_record(KIND_NEWLINE, '0, '0, height, '0, '0);
      end

      case (phase)
        PH_BLACK: begin
          if (blk) begin
            extend_run(col);
          end else begin
            queue_record(KIND_SEGMENT, run_start, run_len, '0, '0, '0);
            begin_run(PH_GAP, col);
          end
        end
        PH_GAP: begin
          if (blk) begin
            queue_record(KIND_SPACE, run_start, run_len, '0, '0, '0);
            wide_sum  = {1'b0, space_sum} + run_len;
            space_sum = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
            if (space_num != '1) space_num = space_num + 1'b1;
            begin_run(PH_BLACK, col);
          end else begin
            extend_run(col);
          end
        end
        default: begin
          if (blk) begin_run(PH_BLACK, col);
        end
      endcase

      dots      = '0;
      rows      = '0;
      col_index = col_index + 1'b1;

      if (band_last) begin
        if (phase == PH_BLACK)
          queue_record(KIND_SEGMENT, run_start, run_len, '0, '0, '0);
        queue_record(KIND_END, '0, '0, '0, space_sum, space_num);
        phase     = PH_LEAD;
        run_start = '0;
        run_len   = '0;
        first_col = 1'b1;
        col_index = '0;
        height    = '0;
      end

      if (batch.size() > 0) begin
        batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) expected.push_back(batch[i]);
      end
    endfunction

    function void match_field(string name, longint unsigned want,
                              longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_record(logic [1:0] kind, logic [71:0] data, logic last);
      cps_rec_t want;
      if (expected.size() == 0) begin
        $error("record with nothing pending: kind %0d data %h", kind, data);
        errors++;
        return;
      end
      want = expected.pop_front();
      match_field("kind",        want.kind,        kind);
      match_field("position",    want.position,    data[9:0]);
      match_field("seg_width",   want.seg_width,   data[20:10]);
      match_field("band_height", want.band_height, data[31:21]);
      match_field("space_sum",   want.space_sum,   data[55:32]);
      match_field("space_tally", want.space_tally, data[71:56]);
      match_field("last",        want.last,        last);
    endfunction
  endclass

endpackage

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: bench for the column projection segmenter
// Streams text bands pixel by pixel under bursty input and a stalling
// receiver, predicts every result record and checks each one in order.
// ----------------------------------------------------------------------------
module tb_top;
  import cps_pkg::*;
  import cps_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000; // cycles without any transfer
  localparam int DRAIN_CYCLES   = 8;    // empties the input register and result queue
  localparam int RANDOM_ITEMS   = 368;  // bands overshoot each phase goal
  localparam int RANDOM_PHASES  = 8;

  // column shading used to shape pixel values
  localparam int SHADE_WHITE = 0;
  localparam int SHADE_BLACK = 1;
  localparam int SHADE_MIXED = 2;
  localparam int SHADE_NOISE = 3;

  // receiver stall patterns
  localparam int RX_OPEN   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_TOGGLE = 3;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;   // [7:0] pixel
  logic [1:0]  in_tuser    = '0;   // [0] last_in_column, [1] new_image
  logic        in_tlast    = 1'b0; // last_in_band
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [71:0] out_tdata;          // [9:0] position, [20:10] seg_width,
                                   // [31:21] band_height, [55:32] space_sum,
                                   // [71:56] space_tally
  logic [1:0]  out_tuser;          // [1:0] kind
  logic        out_tlast;          // last
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  segment_tracker tracker;

  // stimulus-side copy of the black level, used to pick pixel values
  logic [7:0] cur_level   = 8'd128;
  int         burst_left  = 0;
  int         items_sent  = 0;
  int         idle_cycles = 0;
  int         rx_mode     = RX_OPEN;
  int         rx_left     = 0;

  column_projection_segmenter_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // Receiver: switches between stall patterns at random intervals so
  // that back pressure hits single records as well as full three-record
  // bursts; the open pattern gives stretches with no stall at all.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(RX_OPEN, RX_TOGGLE);
      rx_left <= $urandom_range(10, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
      default:   out_tready <= ~out_tready;
    endcase
  end

  // Result monitor: every output transfer is checked against the oldest
  // pending record.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_record(out_tuser, out_tdata, out_tlast);
  end

  // Watchdog: any transfer on any port restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One pixel transfer. The sender runs in bursts; when a burst is used up
  // tvalid drops for a short random gap before the next one starts.
  task automatic send_pixel(input logic [7:0] pix, input logic col_last,
                            input logic band_last, input logic new_img);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= {new_img, col_last};
    in_tlast  <= band_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_pixel(pix, col_last, band_last, new_img);
    items_sent++;
  endtask

  // Called in the step of the last accepted transfer, so tvalid gets only
  // this one update in that step.
  task automatic stop_input();
    in_tvalid <= 1'b0;
  endtask

  // Wait for all pending records, then let the pipeline empty so a pixel
  // with no records cannot be in flight during a register write.
  task automatic settle();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup then access phase; psel stays high across back-to-back writes.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    tracker.set_reg(idx, value);
  endtask

  task automatic write_config(input logic [10:0] width, input logic [10:0] thr,
                              input logic [7:0] level);
    write_reg(REG_IMAGE_WIDTH, {21'd0, width});
    write_reg(REG_COL_THRESH, {21'd0, thr});
    write_reg(REG_BLACK_LEVEL, {24'd0, level});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cur_level = level;
  endtask

  // Values right at the black level boundary show up now and then.
  function automatic logic [7:0] pick_pixel(input int shade);
    int s;
    s = shade;
    if (shade == SHADE_MIXED) s = $urandom_range(0, 1) ? SHADE_BLACK : SHADE_WHITE;
    if (s == SHADE_BLACK && cur_level != 8'd0) begin
      if ($urandom_range(0, 5) == 0) return cur_level - 8'd1;
      return 8'($urandom_range(0, cur_level - 1));
    end
    if (s == SHADE_WHITE) begin
      if ($urandom_range(0, 5) == 0) return cur_level;
      return 8'($urandom_range(cur_level, 255));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Well-formed band: columns of mostly equal height, band end on the last
  // pixel, sometimes without the column-end flag.
  task automatic send_band(input int ncols, input int height);
    int   len;
    int   shade;
    logic ni_first;
    ni_first = ($urandom_range(0, 3) != 0);
    for (int c = 0; c < ncols; c++) begin
      shade = $urandom_range(SHADE_WHITE, SHADE_NOISE);
      len   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, height + 2) : height;
      for (int r = 0; r < len; r++) begin
        logic lic;
        logic lib;
        logic ni;
        lic = (r == len - 1);
        lib = (c == ncols - 1) && (r == len - 1);
        if (lib && $urandom_range(0, 2) == 0) lic = 1'b0;
        ni = (c == 0 && r == 0) ? ni_first : ($urandom_range(0, 63) == 0);
        send_pixel(pick_pixel(shade), lic, lib, ni);
      end
    end
  endtask

  // Broken band: column ends at random points, stray new-image flags.
  task automatic send_scrap();
    int n;
    n = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      send_pixel(8'($urandom_range(0, 255)), ($urandom_range(0, 2) == 0) || (i == n - 1),
                 (i == n - 1), ($urandom_range(0, 7) == 0));
    end
  endtask

  // Reset defaults: width 1024, threshold 1, black level 128.
  task automatic run_directed();
    // leading white, black run of two (127 and 0 are black), white gap,
    // black column, trailing white column closing the band
    send_pixel(8'd255, 1'b0, 1'b0, 1'b1);
    send_pixel(8'd200, 1'b1, 1'b0, 1'b0);
    send_pixel(8'd127, 1'b0, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b0, 1'b0);
    send_pixel(8'd0,   1'b0, 1'b0, 1'b0);
    send_pixel(8'd128, 1'b1, 1'b0, 1'b0);
    send_pixel(8'd128, 1'b0, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0, 1'b0);
    send_pixel(8'd0,   1'b1, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b1, 1'b0);
    // single black column, band end without column end: three records
    send_pixel(8'd0, 1'b0, 1'b0, 1'b1);
    send_pixel(8'd0, 1'b0, 1'b0, 1'b0);
    send_pixel(8'd0, 1'b0, 1'b1, 1'b0);
    // no new image: totals carry over; black, white, black
    send_pixel(8'd0,   1'b1, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b0, 1'b0);
    send_pixel(8'd0,   1'b1, 1'b1, 1'b0);
  endtask

  initial begin
    int          phase_goal;
    logic [10:0] width;
    logic [10:0] thr;
    logic [7:0]  level;
    tracker = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // Random phases; the first two pin the register extremes.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      stop_input();
      settle();
      case (p)
        0: write_config(11'd1, 11'd0, 8'd255);
        1: write_config(11'd1024, 11'd1024, 8'd0);
        default: begin
          width = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(1, 1024))
                                              : 11'($urandom_range(1, 16));
          thr   = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 1024))
                                              : 11'($urandom_range(0, 5));
          level = 8'($urandom_range(1, 255));
          write_config(width, thr, level);
        end
      endcase
      phase_goal = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < phase_goal) begin
        if ($urandom_range(0, 7) == 0)
          send_scrap();
        else
          send_band($urandom_range(1, 8), ($urandom_range(0, 9) == 0) ?
                    $urandom_range(7, 24) : $urandom_range(1, 6));
      end
    end

    stop_input();
    settle();
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
